// File: hdl/plc_frame_deframer_assert.svh
// Assertion macros shared by the frame deframer checker.
`ifndef PLC_FRAME_DEFRAMER_ASSERT_SVH
`define PLC_FRAME_DEFRAMER_ASSERT_SVH

// Check a property on each rising edge while out of reset.
`define PLCFD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each rising edge, reset cycles included.
`define PLCFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/plcfd_pkg.sv
// Shared types and constants of the frame deframer.
package plcfd_pkg;

    localparam logic [7:0] START_BYTE    = 8'h68;
    localparam logic [7:0] END_BYTE      = 8'h16;
    localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
    localparam int         ADDR_FLAG_BIT = 2;      // bit of the 0x04 mask

    localparam logic [1:0] PRE_LAST = 2'd3;        // fourth preamble byte

    // Byte positions counted from the start byte (position 0).
    localparam int POS_LEN_LO = 1;
    localparam int POS_LEN_HI = 2;
    localparam int POS_CTRL   = 3;
    localparam int POS_INFO0  = 4;
    localparam int SRC_FIRST  = 10;
    localparam int SRC_BYTES  = 6;
    localparam int HDR_PLAIN  = 10;                // AFN position without addresses
    localparam int HDR_ADDR   = 22;                // AFN position with addresses
    localparam int LEN_MARGIN = 5;                 // AFN, FN, checksum and end byte

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_NEED_START,
        PH_FRAME
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_START = 3'd1;
    localparam logic [2:0] ERR_SHORT    = 3'd2;
    localparam logic [2:0] ERR_SUM      = 3'd3;
    localparam logic [2:0] ERR_END      = 3'd4;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload;
        logic [7:0]  afn;
        logic [15:0] fn;
        logic        has_addr;
        logic [47:0] source;
        logic [2:0]  err;
    } t_result;

endpackage

// File: hdl/plc_frame_deframer.sv
// Top level of the byte-serial power line carrier frame deframer.
// A byte reaches the output through the input register and then the result register.
// Throughput: one byte per cycle while the result channel keeps taking results;
// set by the single input register feeding the parser and the single result register.
// Reset (i_rst_n low, synchronous) returns to hunt, clears all held frame
// fields to zero and empties the input and result registers.
module plc_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_app_function,
    output logic [15:0] o_data_unit_id,
    output logic        o_has_address,
    output logic [47:0] o_source_address,
    output logic [2:0]  o_error_code
);

    // Input register: holds one byte so that a new transaction can be taken
    // while a finished result still waits on the output side.
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    logic               w_rx_take;
    logic               w_advance;
    logic               w_core_valid;
    plcfd_pkg::t_result w_core_res;
    logic               w_out_valid;
    plcfd_pkg::t_result w_out_res;

    // Advance the parser whenever a byte is held and the result register is free or draining.
    assign w_advance  = r_in_valid && (!w_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || w_advance;
    assign w_rx_take  = i_rx_valid && o_rx_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_rx_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Parser: one byte per step, at most one result per step.
    plcfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_byte      (r_in_byte),
        .o_res_valid (w_core_valid),
        .o_res       (w_core_res)
    );

    // Result register: load only when the parser produces a transaction.
    plcfd_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_core_valid),
        .i_res   (w_core_res),
        .i_ready (i_res_ready),
        .o_valid (w_out_valid),
        .o_res   (w_out_res)
    );

    assign o_res_valid      = w_out_valid;
    assign o_result_kind    = w_out_res.kind;
    assign o_payload_byte   = w_out_res.payload;
    assign o_app_function   = w_out_res.afn;
    assign o_data_unit_id   = w_out_res.fn;
    assign o_has_address    = w_out_res.has_addr;
    assign o_source_address = w_out_res.source;
    assign o_error_code     = w_out_res.err;

endmodule

// File: hdl/plcfd_core.sv
// Frame parser: phase tracking, header capture, checksum and result decode.
module plcfd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output plcfd_pkg::t_result o_res
);

    plcfd_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_run, n_run;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_sum, n_sum;
    logic        r_flag, n_flag;
    logic [7:0]  r_afn, n_afn;
    logic [15:0] r_fn, n_fn;
    logic [47:0] r_src, n_src;

    logic [15:0] w_h;
    logic [15:0] w_hdr_last;
    logic [15:0] w_cks_pos;
    logic        w_start, w_pre, w_in_hdr, w_hdr_end, w_short;
    logic        w_in_body, w_at_cks, w_sum_bad;
    logic        w_res_valid;
    plcfd_pkg::t_kind w_kind;
    logic [7:0]  w_payload;
    logic [2:0]  w_err;

    assign w_start    = (i_byte == plcfd_pkg::START_BYTE);
    assign w_pre      = (i_byte == plcfd_pkg::PREAMBLE_BYTE);
    assign w_h        = r_flag ? 16'(plcfd_pkg::HDR_ADDR) : 16'(plcfd_pkg::HDR_PLAIN);
    assign w_hdr_last = w_h + 16'd2;
    assign w_in_hdr   = (r_pos <= w_hdr_last);
    assign w_hdr_end  = (r_pos == w_hdr_last);
    assign w_short    = (r_len < (w_h + 16'(plcfd_pkg::LEN_MARGIN)));
    assign w_cks_pos  = r_len - 16'd2;
    assign w_in_body  = (r_pos < w_cks_pos);
    assign w_at_cks   = (r_pos == w_cks_pos);
    assign w_sum_bad  = (i_byte != r_sum);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            case (r_phase)
                plcfd_pkg::PH_HUNT: begin
                    if (w_start) begin
                        n_phase = plcfd_pkg::PH_FRAME;
                    end else if (w_pre && (r_run == plcfd_pkg::PRE_LAST)) begin
                        n_phase = plcfd_pkg::PH_NEED_START;
                    end
                end
                plcfd_pkg::PH_NEED_START: begin
                    n_phase = w_start ? plcfd_pkg::PH_FRAME : plcfd_pkg::PH_HUNT;
                end
                plcfd_pkg::PH_FRAME: begin
                    if (w_in_hdr ? (w_hdr_end && w_short)
                                 : (!w_in_body && (!w_at_cks || w_sum_bad))) begin
                        n_phase = plcfd_pkg::PH_HUNT;
                    end
                end
                default: begin
                    n_phase = plcfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Datapath and result decode.
    always_comb begin
        n_run       = r_run;
        n_pos       = r_pos;
        n_len       = r_len;
        n_sum       = r_sum;
        n_flag      = r_flag;
        n_afn       = r_afn;
        n_fn        = r_fn;
        n_src       = r_src;
        w_res_valid = 1'b0;
        w_kind      = plcfd_pkg::KIND_DATA;
        w_payload   = 8'h00;
        w_err       = plcfd_pkg::ERR_NONE;
        if (i_step) begin
            case (r_phase)
                plcfd_pkg::PH_HUNT, plcfd_pkg::PH_NEED_START: begin
                    if (w_start) begin
                        n_run  = 2'd0;
                        n_pos  = 16'd1;
                        n_len  = 16'd0;
                        n_sum  = 8'h00;
                        n_flag = 1'b0;
                        n_afn  = 8'h00;
                        n_fn   = 16'd0;
                        n_src  = 48'd0;
                    end else if (r_phase == plcfd_pkg::PH_NEED_START) begin
                        n_run       = 2'd0;
                        n_pos       = 16'd0;
                        w_res_valid = 1'b1;
                        w_kind      = plcfd_pkg::KIND_REJECT;
                        w_err       = plcfd_pkg::ERR_NO_START;
                    end else if (w_pre) begin
                        n_run = r_run + 2'd1;  // wraps to zero on the fourth
                    end else begin
                        n_run = 2'd0;
                    end
                end
                plcfd_pkg::PH_FRAME: begin
                    n_pos = r_pos + 16'd1;
                    if (w_in_hdr) begin
                        if (r_pos >= 16'(plcfd_pkg::POS_CTRL)) begin
                            n_sum = r_sum + i_byte;
                        end
                        if (r_pos == 16'(plcfd_pkg::POS_LEN_LO)) begin
                            n_len = {8'h00, i_byte};
                        end else if (r_pos == 16'(plcfd_pkg::POS_LEN_HI)) begin
                            n_len = {i_byte, r_len[7:0]};
                        end else if (r_pos == 16'(plcfd_pkg::POS_INFO0)) begin
                            n_flag = i_byte[plcfd_pkg::ADDR_FLAG_BIT];
                        end else if (r_flag && (r_pos >= 16'(plcfd_pkg::SRC_FIRST)) &&
                                     (r_pos < 16'(plcfd_pkg::SRC_FIRST + plcfd_pkg::SRC_BYTES)))
                        begin
                            for (int k = 0; k < plcfd_pkg::SRC_BYTES; k++) begin
                                if (r_pos == 16'(plcfd_pkg::SRC_FIRST + k)) begin
                                    n_src[8*k +: 8] = i_byte;
                                end
                            end
                        end else if (r_pos == w_h) begin
                            n_afn = i_byte;
                        end else if (r_pos == (w_h + 16'd1)) begin
                            n_fn = {8'h00, i_byte};
                        end else if (w_hdr_end) begin
                            n_fn = {i_byte, r_fn[7:0]};
                            if (w_short) begin
                                n_run       = 2'd0;
                                n_pos       = 16'd0;
                                w_res_valid = 1'b1;
                                w_kind      = plcfd_pkg::KIND_REJECT;
                                w_err       = plcfd_pkg::ERR_SHORT;
                            end
                        end
                    end else if (w_in_body) begin
                        n_sum       = r_sum + i_byte;
                        w_res_valid = 1'b1;
                        w_kind      = plcfd_pkg::KIND_DATA;
                        w_payload   = i_byte;
                    end else if (w_at_cks) begin
                        if (w_sum_bad) begin
                            n_run       = 2'd0;
                            n_pos       = 16'd0;
                            w_res_valid = 1'b1;
                            w_kind      = plcfd_pkg::KIND_REJECT;
                            w_err       = plcfd_pkg::ERR_SUM;
                        end
                    end else begin
                        n_run       = 2'd0;
                        n_pos       = 16'd0;
                        w_res_valid = 1'b1;
                        if (i_byte != plcfd_pkg::END_BYTE) begin
                            w_kind = plcfd_pkg::KIND_REJECT;
                            w_err  = plcfd_pkg::ERR_END;
                        end else begin
                            w_kind = plcfd_pkg::KIND_ACCEPT;
                        end
                    end
                end
                default: begin
                    n_run = 2'd0;
                    n_pos = 16'd0;
                end
            endcase
        end
    end

    // Results carry the held fields as they stand after this byte.
    always_comb begin
        o_res_valid     = w_res_valid;
        o_res.kind      = w_kind;
        o_res.payload   = w_payload;
        o_res.afn       = n_afn;
        o_res.fn        = n_fn;
        o_res.has_addr  = n_flag;
        o_res.source    = n_src;
        o_res.err       = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= plcfd_pkg::PH_HUNT;
            r_run   <= 2'd0;
            r_pos   <= 16'd0;
            r_len   <= 16'd0;
            r_sum   <= 8'h00;
            r_flag  <= 1'b0;
            r_afn   <= 8'h00;
            r_fn    <= 16'd0;
            r_src   <= 48'd0;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_flag  <= n_flag;
            r_afn   <= n_afn;
            r_fn    <= n_fn;
            r_src   <= n_src;
        end
    end

endmodule

// File: hdl/plcfd_outreg.sv
// Result register with valid flag on the output channel.
module plcfd_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  plcfd_pkg::t_result i_res,
    input  logic               i_ready,
    output logic               o_valid,
    output plcfd_pkg::t_result o_res
);

    logic               r_valid, n_valid;
    plcfd_pkg::t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/plcfd_checker.sv
// Port-level checks of the frame deframer, bound to the top level.
`include "plc_frame_deframer_assert.svh"

module plcfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  o_result_kind,
    input logic [7:0]  o_payload_byte,
    input logic [7:0]  o_app_function,
    input logic [15:0] o_data_unit_id,
    input logic        o_has_address,
    input logic [47:0] o_source_address,
    input logic [2:0]  o_error_code
);

    logic        w_res_stall;
    logic        w_is_data, w_is_accept, w_is_reject;
    logic        w_err_none, w_err_known, w_pay_zero;
    logic [85:0] w_res_bits;

    assign w_res_stall = o_res_valid && !i_res_ready;
    assign w_is_data   = o_res_valid && (o_result_kind == plcfd_pkg::KIND_DATA);
    assign w_is_accept = o_res_valid && (o_result_kind == plcfd_pkg::KIND_ACCEPT);
    assign w_is_reject = o_res_valid && (o_result_kind == plcfd_pkg::KIND_REJECT);
    assign w_err_none  = (o_error_code == plcfd_pkg::ERR_NONE);
    assign w_err_known = o_error_code inside {[plcfd_pkg::ERR_NO_START:plcfd_pkg::ERR_END]};
    assign w_pay_zero  = (o_payload_byte == 8'h00);
    assign w_res_bits  = {o_result_kind, o_payload_byte, o_app_function, o_data_unit_id,
                          o_has_address, o_source_address, o_error_code};

    // A stalled result stays offered with every field held.
    property p_stall_holds;
        w_res_stall |=> (o_res_valid && $stable(w_res_bits));
    endproperty

    `PLCFD_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_res_valid, "result after reset")

    `PLCFD_ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, p_stall_holds, "stalled result changed")

    `PLCFD_ASSERT_CLK(a_data_no_error, i_clk, i_rst_n, w_is_data |-> w_err_none, "payload with error")

    `PLCFD_ASSERT_CLK(a_reject_coded, i_clk, i_rst_n, w_is_reject |-> (w_err_known && w_pay_zero), "bad reject")

    `PLCFD_ASSERT_CLK(a_accept_clean, i_clk, i_rst_n, w_is_accept |-> (w_err_none && w_pay_zero), "bad accept")

endmodule

bind plc_frame_deframer plcfd_checker u_plcfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_res_valid      (o_res_valid),
    .i_res_ready      (i_res_ready),
    .o_result_kind    (o_result_kind),
    .o_payload_byte   (o_payload_byte),
    .o_app_function   (o_app_function),
    .o_data_unit_id   (o_data_unit_id),
    .o_has_address    (o_has_address),
    .o_source_address (o_source_address),
    .o_error_code     (o_error_code)
);
